/* rtl/rled_pkg.sv */
// ----------------------------------------------------------------------------
// RGB LED dimmer package
// Shared types, codes and constants for the exponential LED dimmer.
// ----------------------------------------------------------------------------
package rled_pkg;

	localparam logic [15:0] PWM_FULL         = 16'd65535;
	localparam logic [31:0] LOG2_MILLION_Q24 = 32'd334396231;
	localparam int          FRAC_BITS        = 24;
	localparam logic [61:0] SQRT_SEED        = 62'h2000_0000_0000_0000;
	localparam logic [31:0] ONE_Q30          = 32'h4000_0000;
	localparam logic [7:0]  LEVEL_MAX        = 8'd255;

	localparam logic CMD_SET     = 1'b0;
	localparam logic CMD_REAPPLY = 1'b1;

	localparam logic [2:0] REG_MAX_CURRENT = 3'd0;
	localparam logic [2:0] REG_RED_ON      = 3'd1;
	localparam logic [2:0] REG_GREEN_ON    = 3'd2;
	localparam logic [2:0] REG_BLUE_ON     = 3'd3;
	localparam logic [2:0] REG_CURVE_SCALE = 3'd4;

	typedef struct packed {
		logic       command;
		logic [7:0] red_value;
		logic [7:0] green_value;
		logic [7:0] blue_value;
	} in_item_t;

	typedef struct packed {
		logic [15:0] red_duty;
		logic [15:0] green_duty;
		logic [15:0] blue_duty;
		logic [14:0] effective_limit_ua;
	} out_item_t;

	typedef enum logic [4:0] {
		ST_ROOT_GO, ST_ROOT_WAIT, ST_IDLE, ST_XMUL, ST_XCAP, ST_NORM,
		ST_LSQ, ST_LCAP, ST_LG, ST_CEM, ST_CED, ST_CEW, ST_PM, ST_PD,
		ST_PQ, ST_PR, ST_PW, ST_ECHK, ST_EMUL, ST_ECAP, ST_FMUL, ST_FCAP,
		ST_NEXT, ST_DONE
	} state_t;

endpackage

/* rtl/rled_mul.sv */
// ----------------------------------------------------------------------------
// RGB LED dimmer shared multiplier
// Unsigned 32 by 32 multiplier with a registered 64-bit product.
// ----------------------------------------------------------------------------
module rled_mul (
	input  logic        clk,
	input  logic [31:0] a,
	input  logic [31:0] b,
	output logic [63:0] p
);
	logic [63:0] p_q;

	always_ff @(posedge clk) begin
		p_q <= 64'(a) * 64'(b);
	end

	assign p = p_q;
endmodule

/* rtl/rled_div.sv */
// ----------------------------------------------------------------------------
// RGB LED dimmer divider
// Restoring divider, 40-bit dividend by 16-bit divisor, one bit per cycle.
// ----------------------------------------------------------------------------
module rled_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [39:0] dividend,
	input  logic [15:0] divisor,
	output logic        done,
	output logic [39:0] quotient
);
	logic [15:0] rem_q;
	logic [39:0] quo_q;
	logic [15:0] dsr_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [16:0] trial;
	logic        fits;

	assign trial = {rem_q, quo_q[39]};
	assign fits  = trial >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= !start && busy_q && cnt_q == 6'd39;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd39) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? 16'(trial - {1'b0, dsr_q}) : trial[15:0];
			quo_q <= {quo_q[38:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;
endmodule

/* rtl/rled_isqrt.sv */
// ----------------------------------------------------------------------------
// RGB LED dimmer square root
// Integer square root of a 62-bit value, two radicand bits per cycle.
// ----------------------------------------------------------------------------
module rled_isqrt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [61:0] radicand,
	output logic        done,
	output logic [31:0] root
);
	logic [63:0] a_q;
	logic [63:0] res_q;
	logic [63:0] bit_q;
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [63:0] sum;

	assign sum = res_q + bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= !start && busy_q && cnt_q == 5'd31;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= {2'b00, radicand};
			res_q <= '0;
			bit_q <= 64'h4000_0000_0000_0000;
		end else if (busy_q) begin
			if (a_q >= sum) begin
				a_q   <= a_q - sum;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign done = done_q;
	assign root = res_q[31:0];
endmodule

/* rtl/rgb_led_exponential_dimmer.sv */
// ----------------------------------------------------------------------------
// RGB LED exponential dimmer
// Maps three 8-bit colour levels to PWM duty counts on an exponential curve,
// balanced by each LED's full-drive current.
// ----------------------------------------------------------------------------
// After reset the block builds its table of 24 square roots, during which no
// request is taken; configuration writes are taken at once.
// A request then runs, from acceptance to result, through a 24-step log and
// three 24-step exp loops on the one multiplier, three 40-step divisions and up
// to six remainder checks per channel; zero levels or a zero limit shorten it.
// The result register frees the input side as soon as the result is loaded.
module rgb_led_exponential_dimmer (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  rled_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output rled_pkg::out_item_t out_data,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [2:0]          cfg_index,
	input  logic [19:0]         cfg_data
);
	rled_pkg::state_t state_q, state_d;

	logic [14:0] max_cur_q;
	logic [15:0] on_q [3];
	logic [19:0] scale_q;
	logic [7:0]  lev_q [3];
	logic [31:0] root_q [24];

	logic [61:0]        sq_in_q;
	logic [14:0]        lim_q;
	logic [34:0]        x_q;
	logic [5:0]         nsh_q;
	logic [30:0]        m_q;
	logic [23:0]        frac_q;
	logic signed [31:0] lg_q;
	logic [15:0]        ceil_q;
	logic [39:0]        dx_q;
	logic [31:0]        dq_q;
	logic [10:0]        dr_q;
	logic signed [33:0] e_q;
	logic [31:0]        r_q;
	logic [15:0]        duty_q [3];
	logic [1:0]         ch_q;
	logic [4:0]         it_q;
	logic               out_valid_q;
	rled_pkg::out_item_t out_q;

	logic [31:0] mul_a, mul_b;
	logic [63:0] mul_p;
	logic        div_start, div_done;
	logic [39:0] div_dividend, div_q;
	logic [15:0] div_divisor;
	logic        sq_start, sq_done;
	logic [31:0] sq_root;

	logic [14:0]        lim_d;
	logic [7:0]         cur_lev;
	logic [31:0]        lg_abs;
	logic [31:0]        m2;
	logic signed [9:0]  k;
	logic [9:0]         sh;
	logic [63:0]        val;
	logic               in_acc;

	rled_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(mul_p));

	rled_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(div_dividend),
		.divisor(div_divisor), .done(div_done), .quotient(div_q)
	);

	rled_isqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .start(sq_start), .radicand(sq_in_q),
		.done(sq_done), .root(sq_root)
	);

	// The limit is the smallest of the requested limit and the three on-currents.
	always_comb begin
		lim_d = max_cur_q;
		for (int c = 0; c < 3; c++) begin
			if ({1'b0, lim_d} > on_q[c]) begin
				lim_d = on_q[c][14:0];
			end
		end
	end

	assign in_acc  = in_valid && in_ready;
	assign cur_lev = lev_q[ch_q];
	assign lg_abs  = lg_q[31] ? 32'(-lg_q) : 32'(lg_q);
	assign m2      = mul_p[61:30];
	assign k       = e_q[33:24];
	assign sh      = 10'(10'sd30 - k);
	assign val     = mul_p >> sh[5:0];

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			rled_pkg::ST_ROOT_GO:   state_d = rled_pkg::ST_ROOT_WAIT;
			rled_pkg::ST_ROOT_WAIT: begin
				if (sq_done) begin
					state_d = (it_q == 5'd23) ? rled_pkg::ST_IDLE : rled_pkg::ST_ROOT_GO;
				end
			end
			rled_pkg::ST_IDLE: begin
				if (in_acc) state_d = rled_pkg::ST_XMUL;
			end
			rled_pkg::ST_XMUL: state_d = rled_pkg::ST_XCAP;
			rled_pkg::ST_XCAP: begin
				state_d = (mul_p == 64'd0) ? rled_pkg::ST_DONE : rled_pkg::ST_NORM;
			end
			rled_pkg::ST_NORM: begin
				if (x_q[34]) state_d = rled_pkg::ST_LSQ;
			end
			rled_pkg::ST_LSQ:  state_d = rled_pkg::ST_LCAP;
			rled_pkg::ST_LCAP: begin
				state_d = (it_q == 5'd23) ? rled_pkg::ST_LG : rled_pkg::ST_LSQ;
			end
			rled_pkg::ST_LG:  state_d = rled_pkg::ST_CEM;
			rled_pkg::ST_CEM: state_d = rled_pkg::ST_CED;
			rled_pkg::ST_CED: state_d = rled_pkg::ST_CEW;
			rled_pkg::ST_CEW: begin
				if (div_done) begin
					state_d = (cur_lev == 8'd0 || div_q[15:0] == 16'd0) ?
						rled_pkg::ST_NEXT : rled_pkg::ST_PM;
				end
			end
			rled_pkg::ST_PM: state_d = rled_pkg::ST_PD;
			rled_pkg::ST_PD: state_d = rled_pkg::ST_PQ;
			rled_pkg::ST_PQ: state_d = rled_pkg::ST_PR;
			rled_pkg::ST_PR: state_d = rled_pkg::ST_PW;
			rled_pkg::ST_PW: begin
				state_d = (dr_q >= 11'(rled_pkg::LEVEL_MAX)) ?
					rled_pkg::ST_PW : rled_pkg::ST_ECHK;
			end
			rled_pkg::ST_ECHK: begin
				state_d = (k >= 10'sd17 || k < -10'sd32) ?
					rled_pkg::ST_NEXT : rled_pkg::ST_EMUL;
			end
			rled_pkg::ST_EMUL: state_d = rled_pkg::ST_ECAP;
			rled_pkg::ST_ECAP: begin
				state_d = (it_q == 5'd23) ? rled_pkg::ST_FMUL : rled_pkg::ST_EMUL;
			end
			rled_pkg::ST_FMUL: state_d = rled_pkg::ST_FCAP;
			rled_pkg::ST_FCAP: state_d = rled_pkg::ST_NEXT;
			rled_pkg::ST_NEXT: begin
				state_d = (ch_q == 2'd2) ? rled_pkg::ST_DONE : rled_pkg::ST_CEM;
			end
			rled_pkg::ST_DONE: begin
				if (!out_valid_q || out_ready) state_d = rled_pkg::ST_IDLE;
			end
			default: state_d = rled_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		mul_a        = '0;
		mul_b        = '0;
		div_start    = 1'b0;
		div_dividend = mul_p[39:0];
		div_divisor  = '0;
		sq_start     = 1'b0;
		in_ready     = 1'b0;
		unique case (state_q)
			rled_pkg::ST_ROOT_GO: sq_start = 1'b1;
			rled_pkg::ST_IDLE:    in_ready = 1'b1;
			rled_pkg::ST_XMUL: begin
				mul_a = 32'(scale_q);
				mul_b = 32'(lim_q);
			end
			rled_pkg::ST_LSQ: begin
				mul_a = 32'(m_q);
				mul_b = 32'(m_q);
			end
			rled_pkg::ST_CEM: begin
				mul_a = 32'(lim_q);
				mul_b = 32'(rled_pkg::PWM_FULL);
			end
			rled_pkg::ST_CED: begin
				div_start   = 1'b1;
				div_divisor = on_q[ch_q];
			end
			rled_pkg::ST_PM: begin
				mul_a = 32'(rled_pkg::LEVEL_MAX - cur_lev);
				mul_b = lg_abs;
			end
			rled_pkg::ST_EMUL: begin
				mul_a = r_q;
				mul_b = root_q[it_q];
			end
			rled_pkg::ST_FMUL: begin
				mul_a = 32'(ceil_q);
				mul_b = r_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rled_pkg::ST_ROOT_GO;
			max_cur_q   <= 15'd20000;
			on_q[0]     <= 16'd20000;
			on_q[1]     <= 16'd20000;
			on_q[2]     <= 16'd20000;
			scale_q     <= 20'd1000;
			lev_q[0]    <= '0;
			lev_q[1]    <= '0;
			lev_q[2]    <= '0;
			it_q        <= '0;
			ch_q        <= '0;
			sq_in_q     <= rled_pkg::SQRT_SEED;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid) begin
				case (cfg_index)
					rled_pkg::REG_MAX_CURRENT: max_cur_q <= cfg_data[14:0];
					rled_pkg::REG_RED_ON:      on_q[0]   <= cfg_data[15:0];
					rled_pkg::REG_GREEN_ON:    on_q[1]   <= cfg_data[15:0];
					rled_pkg::REG_BLUE_ON:     on_q[2]   <= cfg_data[15:0];
					rled_pkg::REG_CURVE_SCALE: scale_q   <= cfg_data;
					default: ;
				endcase
			end
			if (in_acc && in_data.command == rled_pkg::CMD_SET) begin
				lev_q[0] <= in_data.red_value;
				lev_q[1] <= in_data.green_value;
				lev_q[2] <= in_data.blue_value;
			end
			if (state_q == rled_pkg::ST_DONE && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				rled_pkg::ST_ROOT_WAIT: begin
					if (sq_done) begin
						sq_in_q <= {sq_root, 30'd0};
						it_q    <= (it_q == 5'd23) ? 5'd0 : it_q + 5'd1;
					end
				end
				rled_pkg::ST_LCAP: it_q <= (it_q == 5'd23) ? 5'd0 : it_q + 5'd1;
				rled_pkg::ST_LG:   ch_q <= '0;
				rled_pkg::ST_ECHK: it_q <= '0;
				rled_pkg::ST_ECAP: it_q <= (it_q == 5'd23) ? 5'd0 : it_q + 5'd1;
				rled_pkg::ST_NEXT: ch_q <= ch_q + 2'd1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == rled_pkg::ST_ROOT_WAIT && sq_done) begin
			root_q[it_q] <= sq_root;
		end
		case (state_q)
			rled_pkg::ST_IDLE: lim_q <= lim_d;
			rled_pkg::ST_XCAP: begin
				x_q   <= mul_p[34:0];
				nsh_q <= '0;
				if (mul_p == 64'd0) begin
					duty_q[0] <= '0;
					duty_q[1] <= '0;
					duty_q[2] <= '0;
				end
			end
			rled_pkg::ST_NORM: begin
				if (x_q[34]) begin
					m_q    <= x_q[34:4];
					frac_q <= '0;
				end else begin
					x_q   <= {x_q[33:0], 1'b0};
					nsh_q <= nsh_q + 6'd1;
				end
			end
			rled_pkg::ST_LCAP: begin
				// A square at or above two gives the next log bit and halves the mantissa.
				m_q    <= m2[31] ? m2[31:1] : m2[30:0];
				frac_q <= {frac_q[22:0], m2[31]};
			end
			rled_pkg::ST_LG: begin
				lg_q <= signed'({2'b00, 6'(6'd34 - nsh_q), frac_q}
					- rled_pkg::LOG2_MILLION_Q24);
			end
			rled_pkg::ST_CEW: begin
				if (div_done) begin
					ceil_q <= div_q[15:0];
					if (cur_lev == 8'd0 || div_q[15:0] == 16'd0) duty_q[ch_q] <= '0;
				end
			end
			rled_pkg::ST_PD: begin
				// A non-negative product rounds the exponent towards minus infinity.
				dx_q <= lg_q[31] ? mul_p[39:0] : mul_p[39:0] + 40'd254;
			end
			rled_pkg::ST_PQ: begin
				// The sum of shifts by multiples of eight falls short of the quotient
				// by 255 by at most five; the remainder loop adds the rest.
				dq_q <= dx_q[39:8] + 32'(dx_q[39:16]) + 32'(dx_q[39:24])
					+ 32'(dx_q[39:32]);
			end
			rled_pkg::ST_PR: begin
				dr_q <= 11'(dx_q[10:0] - {dq_q[2:0], 8'd0} + dq_q[10:0]);
			end
			rled_pkg::ST_PW: begin
				if (dr_q >= 11'(rled_pkg::LEVEL_MAX)) begin
					dq_q <= dq_q + 32'd1;
					dr_q <= dr_q - 11'(rled_pkg::LEVEL_MAX);
				end else begin
					e_q <= lg_q[31] ? signed'(34'(dq_q)) : -signed'(34'(dq_q));
				end
			end
			rled_pkg::ST_ECHK: begin
				r_q <= rled_pkg::ONE_Q30;
				if (k >= 10'sd17) duty_q[ch_q] <= rled_pkg::PWM_FULL;
				else if (k < -10'sd32) duty_q[ch_q] <= '0;
			end
			rled_pkg::ST_ECAP: begin
				if (e_q[5'(5'd23 - it_q)]) r_q <= m2;
			end
			rled_pkg::ST_FCAP: begin
				duty_q[ch_q] <= (val > 64'(rled_pkg::PWM_FULL)) ? rled_pkg::PWM_FULL : val[15:0];
			end
			rled_pkg::ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					out_q.red_duty           <= duty_q[0];
					out_q.green_duty         <= duty_q[1];
					out_q.blue_duty          <= duty_q[2];
					out_q.effective_limit_ua <= lim_q;
				end
			end
			default: ;
		endcase
	end

	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
endmodule

/* rtl/rled_checker.sv */
// ----------------------------------------------------------------------------
// RGB LED dimmer port checker
// Watches the dimmer's ports for handshake and sequencing slips.
// ----------------------------------------------------------------------------
module rled_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input logic                out_valid,
	input logic                out_ready,
	input rled_pkg::out_item_t out_data
);
	// A stalled result must stay offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result withdrawn while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_data))
		else $error("result changed while stalled");

	// The block works on one request at a time.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request taken while busy");

	// A fresh result only appears at the end of a busy period.
	a_result_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_ready))
		else $error("result appeared without work");
endmodule

bind rgb_led_exponential_dimmer rled_checker u_rled_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);

/* verif/tb_rgb_led_exponential_dimmer.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// RGB LED exponential dimmer testbench
// Drives colour requests through the valid/ready input with random gaps and
// back-pressure, and keeps a bit-exact fixed-point predictor of the duty
// curve. Each result is checked against the oldest predicted duty set.
// The registers are rewritten between phases, extremes first, then random.
// ----------------------------------------------------------------------------
module tb_rgb_led_exponential_dimmer;
	import rled_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	in_item_t    in_data = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	out_item_t   out_data;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [19:0] cfg_data = '0;

	in_item_t  pending_requests[$];
	out_item_t expected_duties[$];
	int        send_idle_pct = 0;
	int        recv_idle_pct = 0;
	int        mismatches = 0;

	// Predictor copy of the register file and the stored levels
	logic [14:0] lim_reg;
	logic [15:0] on_reg[3];
	logic [19:0] scale_reg;
	logic [7:0]  level_store[3];

	rgb_led_exponential_dimmer dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic longint unsigned int_sqrt(longint unsigned a);
		longint unsigned res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > a) bitv >>= 2;
		while (bitv != 0) begin
			if (a >= res + bitv) begin
				a -= res + bitv;
				res = (res >> 1) + bitv;
			end else
				res >>= 1;
			bitv >>= 2;
		end
		return res;
	endfunction

	function automatic longint log2_fixed(longint unsigned x);
		int n;
		longint unsigned m, frac;
		n = 0;
		frac = 0;
		while (n < 63 && (x >> (n + 1)) != 0) n++;
		m = (n <= 30) ? (x << (30 - n)) : (x >> (n - 30));
		for (int i = 0; i < FRAC_BITS; i++) begin
			m = (m * m) >> 30;
			frac <<= 1;
			if (m >= (64'd1 << 31)) begin
				m >>= 1;
				frac |= 1;
			end
		end
		return longint'((unsigned'(64'(n)) << FRAC_BITS) | frac);
	endfunction

	function automatic longint unsigned exp2_fraction(longint unsigned f);
		longint unsigned root, r;
		root = int_sqrt(64'd2 << 60);
		r = 64'd1 << 30;
		for (int i = 1; i <= FRAC_BITS; i++) begin
			if ((f >> (FRAC_BITS - i)) & 1) r = (r * root) >> 30;
			root = int_sqrt(root << 30);
		end
		return r;
	endfunction

	function automatic logic [15:0] curve_duty(logic [7:0] level, longint unsigned ceiling,
			longint lg);
		longint p, e, k, q, one;
		longint unsigned f, val;
		one = 64'sd1 << FRAC_BITS;
		if (level == 0 || ceiling == 0) return 16'd0;
		p = longint'(255 - int'(level)) * lg;
		if (p >= 0) e = -((p + 254) / 255);
		else e = (-p) / 255;
		if (e >= 0) begin
			k = e / one;
			f = unsigned'(e - k * one);
		end else begin
			q = (-e + one - 1) / one;
			k = -q;
			f = unsigned'(e + q * one);
		end
		if (k >= 17) return PWM_FULL;
		if (k < -32) return 16'd0;
		val = (ceiling * exp2_fraction(f)) >> (30 - k);
		if (val > PWM_FULL) val = PWM_FULL;
		return val[15:0];
	endfunction

	function automatic out_item_t predict_duties(in_item_t req);
		out_item_t res;
		longint unsigned lim, x, ceiling;
		longint lg;
		logic [15:0] duty[3];
		if (req.command == CMD_SET) begin
			level_store[0] = req.red_value;
			level_store[1] = req.green_value;
			level_store[2] = req.blue_value;
		end
		lim = lim_reg;
		for (int c = 0; c < 3; c++)
			if (on_reg[c] < lim) lim = on_reg[c];
		x = 64'(scale_reg) * lim;
		lg = (x != 0) ? log2_fixed(x) - longint'(LOG2_MILLION_Q24) : 0;
		for (int c = 0; c < 3; c++) begin
			duty[c] = 16'd0;
			if (x != 0) begin
				ceiling = (lim * PWM_FULL) / on_reg[c];
				if (ceiling > PWM_FULL) ceiling = PWM_FULL;
				duty[c] = curve_duty(level_store[c], ceiling, lg);
			end
		end
		res.red_duty = duty[0];
		res.green_duty = duty[1];
		res.blue_duty = duty[2];
		res.effective_limit_ua = lim[14:0];
		return res;
	endfunction

	// Request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready)
				expected_duties.push_back(predict_duties(in_data));
			if (!in_valid || in_ready) begin
				if (pending_requests.size() != 0 &&
						$urandom_range(0, 99) >= send_idle_pct) begin
					in_valid <= 1'b1;
					in_data <= pending_requests.pop_front();
				end else
					in_valid <= 1'b0;
			end
		end
	end

	// Result monitor
	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_duties.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result %p", out_data);
				end else begin
					want = expected_duties.pop_front();
					if (out_data.red_duty !== want.red_duty ||
							out_data.green_duty !== want.green_duty ||
							out_data.blue_duty !== want.blue_duty ||
							out_data.effective_limit_ua !== want.effective_limit_ua) begin
						mismatches++;
						if (mismatches <= 10)
							$display("duty mismatch: expected %p, got %p", want, out_data);
					end
				end
			end
			out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	task automatic write_reg(logic [2:0] idx, logic [19:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_MAX_CURRENT: lim_reg = value[14:0];
			REG_RED_ON:      on_reg[0] = value[15:0];
			REG_GREEN_ON:    on_reg[1] = value[15:0];
			REG_BLUE_ON:     on_reg[2] = value[15:0];
			REG_CURVE_SCALE: scale_reg = value;
			default: ;
		endcase
		cfg_valid <= 1'b0;
	endtask

	task automatic wait_drained();
		wait (pending_requests.size() == 0 && !in_valid && expected_duties.size() == 0);
		repeat (30) @(posedge clk);
	endtask

	task automatic queue_request(logic cmd, logic [7:0] r, logic [7:0] g, logic [7:0] b);
		in_item_t req;
		req.command = cmd;
		req.red_value = r;
		req.green_value = g;
		req.blue_value = b;
		pending_requests.push_back(req);
	endtask

	function automatic logic [7:0] random_level();
		case ($urandom_range(0, 9))
			0: return 8'd0;
			1: return 8'd255;
			2: return 8'd1;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	initial begin
		logic [19:0] phase_cfg[5];
		lim_reg = 15'd20000;
		on_reg[0] = 16'd20000;
		on_reg[1] = 16'd20000;
		on_reg[2] = 16'd20000;
		scale_reg = 20'd1000;
		level_store[0] = '0;
		level_store[1] = '0;
		level_store[2] = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Directed requests on the reset settings, reapply before any set first
		queue_request(CMD_REAPPLY, 8'hff, 8'hff, 8'hff);
		queue_request(CMD_SET, 8'd0, 8'd0, 8'd0);
		queue_request(CMD_SET, 8'd255, 8'd255, 8'd255);
		queue_request(CMD_SET, 8'd1, 8'd1, 8'd1);
		queue_request(CMD_SET, 8'd128, 8'd64, 8'd200);
		queue_request(CMD_REAPPLY, 8'h00, 8'h55, 8'haa);
		queue_request(CMD_SET, 8'd0, 8'd255, 8'd1);
		queue_request(CMD_SET, 8'haa, 8'h55, 8'hfe);
		queue_request(CMD_SET, 8'h7f, 8'h80, 8'h01);
		wait_drained();

		for (int phase = 0; phase < 12; phase++) begin
			send_idle_pct = (phase < 4) ? 25 : (phase < 8) ? 65 : 0;
			recv_idle_pct = (phase < 4) ? 65 : (phase < 8) ? 25 : 0;
			case (phase)
				0: phase_cfg = '{20'd0, 20'd20000, 20'd20000, 20'd20000, 20'd1000};
				1: phase_cfg = '{20'd1, 20'd20000, 20'd20000, 20'd20000, 20'd1};
				2: phase_cfg = '{20'd20000, 20'd20000, 20'd20000, 20'd20000, 20'd0};
				3: phase_cfg = '{20'hfffff, 20'hfffff, 20'hfffff, 20'hfffff, 20'hfffff};
				4: phase_cfg = '{20'd20000, 20'd0, 20'd30000, 20'd65535, 20'd1000};
				5: phase_cfg = '{20'd5000, 20'd10000, 20'd20000, 20'd40000, 20'd1000000};
				default: begin
					phase_cfg[0] = ($urandom_range(0, 3) == 0) ?
						20'($urandom_range(0, 20'hfffff)) : 20'($urandom_range(0, 20000));
					for (int c = 1; c < 4; c++)
						phase_cfg[c] = ($urandom_range(0, 1) == 0) ?
							20'($urandom_range(0, 20'hfffff)) : 20'($urandom_range(1000, 30000));
					phase_cfg[4] = ($urandom_range(0, 1) == 0) ?
						20'($urandom_range(0, 20'hfffff)) : 20'($urandom_range(1, 3000));
				end
			endcase
			write_reg(REG_MAX_CURRENT, phase_cfg[0]);
			write_reg(REG_RED_ON, phase_cfg[1]);
			write_reg(REG_GREEN_ON, phase_cfg[2]);
			write_reg(REG_BLUE_ON, phase_cfg[3]);
			write_reg(REG_CURVE_SCALE, phase_cfg[4]);
			// An index past the register list must change nothing
			write_reg(3'($urandom_range(5, 7)), 20'($urandom()));

			for (int i = 0; i < 90; i++) begin
				if ($urandom_range(0, 4) == 0)
					queue_request(CMD_REAPPLY, 8'($urandom()), 8'($urandom()), 8'($urandom()));
				else
					queue_request(CMD_SET, random_level(), random_level(), random_level());
			end
			// Leave a stretch without idling inside the throttled phases
			wait (pending_requests.size() < 20);
			send_idle_pct = 0;
			recv_idle_pct = 0;
			wait_drained();
		end

		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	initial begin
		#20000000;
		$display("FAILURE");
		$finish;
	end

endmodule
